### sv/sdp_pkg.sv
// ============================================================================
// sdp_pkg - shared types and constants for the substitute definition parser
// Holds the parse phase type, the status and result kind codes, the special
// characters of the definition syntax and the item types that travel between
// the front end, the queue and the back end.
// ============================================================================
package sdp_pkg;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_DELIM   = 3'd1,
        PH_PATTERN = 3'd2,
        PH_ACTION  = 3'd3,
        PH_FLAGS   = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_BADPREFIX = 2'd2;
    localparam logic [1:0] ST_BADFLAG   = 2'd3;

    localparam logic [1:0] KIND_PATTERN = 2'd0;
    localparam logic [1:0] KIND_ACTION  = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [7:0] CH_M   = 8'h6D;
    localparam logic [7:0] CH_S   = 8'h73;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_I   = 8'h69;
    localparam logic [7:0] CH_G   = 8'h67;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_V   = 8'h76;
    localparam logic [7:0] CH_NUL = 8'h00;

    // Definitions shorter than this are malformed.
    localparam logic [1:0] MIN_LEN = 2'd3;

    // One decoded input item: up to three results (backslash, byte, verdict).
    typedef struct packed {
        logic [1:0] byte_kind;
        logic [7:0] ch;
        logic       emit_bs;
        logic       emit_ch;
        logic       emit_verdict;
        logic [1:0] status;
        logic       is_sub;
        logic [3:0] flags;
    } packet_t;

    // Queue status seen by the front end and the back end.
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

### sv/sdp_front.sv
// ============================================================================
// sdp_front - byte classifier of the substitute definition parser
// Accepts one definition byte a cycle while the queue has room, updates the
// parse state and hands the queue a packet of that byte's results, if any.
// ============================================================================
module sdp_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_ch,
    input  logic                   in_last,
    input  sdp_pkg::queue_status_t q_status,
    output logic                   push,
    output sdp_pkg::packet_t       push_data
);

    sdp_pkg::phase_t phase_reg, phase_next;
    logic            esc_reg, esc_next;
    logic [7:0]      delim_reg, delim_next;
    logic            sub_reg, sub_next;
    logic [3:0]      flags_reg, flags_next;
    logic [1:0]      err_reg, err_next;
    logic [1:0]      len_reg, len_next;
    logic            accept;
    logic            stop;
    logic [1:0]      stop_err;
    logic            emit_bs, emit_ch;
    logic [1:0]      verdict;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        delim_next = delim_reg;
        sub_next   = sub_reg;
        flags_next = flags_reg;
        len_next   = (len_reg < sdp_pkg::MIN_LEN) ? len_reg + 2'd1 : len_reg;
        stop       = 1'b0;
        stop_err   = sdp_pkg::ST_OK;
        emit_bs    = 1'b0;
        emit_ch    = 1'b0;

        if (phase_reg != sdp_pkg::PH_DONE && in_ch == sdp_pkg::CH_NUL) begin
            // A zero byte ends the definition; only in the flags is that clean.
            priority if (phase_reg == sdp_pkg::PH_PREFIX) begin
                stop     = 1'b1;
                stop_err = sdp_pkg::ST_BADPREFIX;
            end else if (phase_reg == sdp_pkg::PH_FLAGS) begin
                phase_next = sdp_pkg::PH_DONE;
            end else begin
                stop     = 1'b1;
                stop_err = sdp_pkg::ST_MALFORMED;
            end
        end else begin
            unique case (phase_reg)
                sdp_pkg::PH_PREFIX: begin
                    priority if (in_ch == sdp_pkg::CH_M) begin
                        sub_next   = 1'b0;
                        phase_next = sdp_pkg::PH_DELIM;
                    end else if (in_ch == sdp_pkg::CH_S) begin
                        sub_next   = 1'b1;
                        phase_next = sdp_pkg::PH_DELIM;
                    end else begin
                        stop     = 1'b1;
                        stop_err = sdp_pkg::ST_BADPREFIX;
                    end
                end
                sdp_pkg::PH_DELIM: begin
                    delim_next = in_ch;
                    esc_next   = 1'b0;
                    phase_next = sdp_pkg::PH_PATTERN;
                end
                sdp_pkg::PH_PATTERN, sdp_pkg::PH_ACTION: begin
                    // The delimiter test comes before the escape test.
                    if (!esc_reg) begin
                        priority if (in_ch == delim_reg) begin
                            phase_next = (phase_reg == sdp_pkg::PH_PATTERN && sub_reg) ?
                                         sdp_pkg::PH_ACTION : sdp_pkg::PH_FLAGS;
                        end else if (in_ch == sdp_pkg::CH_BSL) begin
                            esc_next = 1'b1;
                        end else begin
                            emit_ch = 1'b1;
                        end
                    end else begin
                        // An escaped delimiter loses its backslash.
                        emit_bs  = (in_ch != delim_reg);
                        emit_ch  = 1'b1;
                        esc_next = 1'b0;
                    end
                end
                sdp_pkg::PH_FLAGS: begin
                    priority if (in_ch == sdp_pkg::CH_I) begin
                        flags_next = flags_reg | 4'b0001;
                    end else if (in_ch == sdp_pkg::CH_G) begin
                        flags_next = flags_reg | 4'b0010;
                    end else if (in_ch == sdp_pkg::CH_U) begin
                        flags_next = flags_reg | 4'b0100;
                    end else if (in_ch == sdp_pkg::CH_V) begin
                        flags_next = flags_reg | 4'b1000;
                    end else begin
                        stop     = 1'b1;
                        stop_err = sdp_pkg::ST_BADFLAG;
                    end
                end
                default: begin
                end
            endcase
        end

        if (stop) begin
            phase_next = sdp_pkg::PH_DONE;
        end
        err_next = (stop && err_reg == sdp_pkg::ST_OK) ? stop_err : err_reg;

        priority if (len_next < sdp_pkg::MIN_LEN) begin
            verdict = sdp_pkg::ST_MALFORMED;
        end else if (err_next != sdp_pkg::ST_OK) begin
            verdict = err_next;
        end else if (phase_next == sdp_pkg::PH_FLAGS || phase_next == sdp_pkg::PH_DONE) begin
            verdict = sdp_pkg::ST_OK;
        end else begin
            verdict = sdp_pkg::ST_MALFORMED;
        end

        push_data.byte_kind    = (phase_reg == sdp_pkg::PH_ACTION) ?
                                 sdp_pkg::KIND_ACTION : sdp_pkg::KIND_PATTERN;
        push_data.ch           = in_ch;
        push_data.emit_bs      = emit_bs;
        push_data.emit_ch      = emit_ch;
        push_data.emit_verdict = in_last;
        push_data.status       = verdict;
        push_data.is_sub       = sub_next;
        push_data.flags        = flags_next;
    end

    assign push = accept && (emit_bs || emit_ch || in_last);

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && in_last)) begin
            phase_reg <= sdp_pkg::PH_PREFIX;
            esc_reg   <= 1'b0;
            delim_reg <= 8'd0;
            sub_reg   <= 1'b0;
            flags_reg <= 4'd0;
            err_reg   <= sdp_pkg::ST_OK;
            len_reg   <= 2'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            delim_reg <= delim_next;
            sub_reg   <= sub_next;
            flags_reg <= flags_next;
            err_reg   <= err_next;
            len_reg   <= len_next;
        end
    end

    a_reset_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_last) |=> (phase_reg == sdp_pkg::PH_PREFIX && len_reg == 2'd0))
        else $error("parse state not cleared after last byte");

    // A zero byte right after a backslash stops parsing with the escape still set.
    a_escape_only_in_body: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (phase_reg == sdp_pkg::PH_PATTERN || phase_reg == sdp_pkg::PH_ACTION ||
                     phase_reg == sdp_pkg::PH_DONE))
        else $error("escape pending outside pattern or action");

endmodule

### sv/sdp_queue.sv
// ============================================================================
// sdp_queue - short packet queue between front end and back end
// Register-based FIFO of decoded packets so that input and output can stall
// independently of each other.
// ============================================================================
module sdp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  sdp_pkg::packet_t       push_data,
    input  logic                   pop,
    output sdp_pkg::packet_t       head,
    output sdp_pkg::queue_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sdp_pkg::packet_t entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign status.valid = (cnt_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;

    always_comb begin
        cnt_next = cnt_reg;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full))
        else $error("packet pushed into full queue");

endmodule

### sv/sdp_back.sv
// ============================================================================
// sdp_back - result emitter of the substitute definition parser
// Unpacks queued packets into single results and drives the registered
// output stream, one result a cycle while out_ready is high and work is waiting.
// ============================================================================
module sdp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sdp_pkg::queue_status_t q_status,
    input  sdp_pkg::packet_t       head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_kind,
    output logic [7:0]             out_char,
    output logic [1:0]             out_status,
    output logic                   out_sub,
    output logic [3:0]             out_flags,
    output logic                   out_end
);

    sdp_pkg::packet_t cur_reg, cur_next;
    logic [2:0]       pend_reg, pend_next;   // {verdict, byte, backslash}
    logic [2:0]       sel, rest, pend_after;
    logic             adv;
    logic             valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       char_reg;
    logic [1:0]       status_reg;
    logic             sub_reg;
    logic [3:0]       flags_reg;
    logic             end_reg;

    assign adv        = (pend_reg != 3'b000) && (!valid_reg || out_ready);
    assign sel        = pend_reg & (~pend_reg + 3'b001);
    assign rest       = pend_reg & ~sel;
    assign pend_after = adv ? rest : pend_reg;
    assign pop        = (pend_after == 3'b000) && q_status.valid;

    always_comb begin
        cur_next  = pop ? head : cur_reg;
        pend_next = pop ? {head.emit_verdict, head.emit_ch, head.emit_bs} : pend_after;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 3'b000;
            valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (adv) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (adv) begin
            end_reg <= (rest == 3'b000);
            if (sel[2]) begin
                kind_reg   <= sdp_pkg::KIND_VERDICT;
                char_reg   <= 8'd0;
                status_reg <= cur_reg.status;
                sub_reg    <= cur_reg.is_sub;
                flags_reg  <= cur_reg.flags;
            end else begin
                kind_reg   <= cur_reg.byte_kind;
                char_reg   <= sel[0] ? sdp_pkg::CH_BSL : cur_reg.ch;
                status_reg <= sdp_pkg::ST_OK;
                sub_reg    <= 1'b0;
                flags_reg  <= 4'd0;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_char   = char_reg;
    assign out_status = status_reg;
    assign out_sub    = sub_reg;
    assign out_flags  = flags_reg;
    assign out_end    = end_reg;

    a_verdict_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == sdp_pkg::KIND_VERDICT) |-> end_reg)
        else $error("verdict result without end of run");

    a_byte_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg != sdp_pkg::KIND_VERDICT) |->
        (status_reg == sdp_pkg::ST_OK && !sub_reg && flags_reg == 4'd0))
        else $error("byte result carries verdict fields");

endmodule

### sv/substitute_definition_parser_top.sv
// ============================================================================
// substitute_definition_parser_top - sed-style m/re/ and s/re/act/ parser
// Streams a match or substitute definition one byte per item and emits the
// decoded pattern and action bytes followed by a verdict on the last byte.
// ============================================================================
// Path: an accepted item's packet waits in the queue, is taken into the back
//   end's packet register and leaves as results through the output register.
// Throughput: one input item and one result per cycle while m_tready is high;
//   items yielding two or three results fill the queue until the input stalls.
// Reset: aresetn is synchronous and active low; it returns the parser to
//   the prefix phase and empties the queue and the output register.
// ============================================================================
module substitute_definition_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream: one definition byte per item.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    input  logic        s_tlast,    // last byte of the definition
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_char, [9:8] status,
                                    // [10] is_substitute, [14:11] flag_bits,
                                    // [15] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast     // last result caused by an input item
);

    sdp_pkg::queue_status_t q_status;
    sdp_pkg::packet_t       push_data;
    sdp_pkg::packet_t       head;
    logic                   push;
    logic                   pop;
    logic [7:0]             out_char;
    logic [1:0]             out_status;
    logic                   out_sub;
    logic [3:0]             out_flags;

    // The front end parses each byte as soon as it is accepted and describes
    // its results (an escape backslash, the byte itself, a verdict) in one
    // packet. Bytes that produce nothing never enter the queue.
    sdp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_ch     (s_tdata),
        .in_last   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // The queue absorbs bursts of multi-result items while output stalls.
    sdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // The back end unpacks each packet into single results and keeps the
    // output register full whenever work is waiting.
    sdp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_char   (out_char),
        .out_status (out_status),
        .out_sub    (out_sub),
        .out_flags  (out_flags),
        .out_end    (m_tlast)
    );

    assign m_tdata = {1'b0, out_flags, out_sub, out_status, out_char};

endmodule
